FILE: rtl/core/mit_pkg.sv
// mit_pkg: shared types and constants for the moving inversion memory test
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mit_pkg;

    localparam int ADDR_WIDTH = 32;
    localparam int DATA_WIDTH = 32;
    localparam int PADDR_WIDTH = 4;
    localparam int PDATA_WIDTH = 32;

    localparam logic [ADDR_WIDTH-1:0] WORD_STEP = ADDR_WIDTH'(4);
    localparam logic [DATA_WIDTH-1:0] PATTERN_RESET = DATA_WIDTH'(32'h5555_aaaa);
    localparam logic [ADDR_WIDTH-1:0] LIMIT_RESET = ADDR_WIDTH'(32'h0010_0000);

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_START = 2'd0,
        REG_END = 2'd1,
        REG_PATTERN = 2'd2,
        REG_LIMIT = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ = 2'd2
    } op_t;

    typedef enum logic [7:0] {
        PH_IDLE = 8'b0000_0001,
        PH_FILL = 8'b0000_0010,
        PH_UPRD = 8'b0000_0100,
        PH_UPWR = 8'b0000_1000,
        PH_DNRD = 8'b0001_0000,
        PH_DNWR = 8'b0010_0000,
        PH_PASS = 8'b0100_0000,
        PH_FAIL = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] start_address;
        logic [ADDR_WIDTH-1:0] end_address;
        logic [DATA_WIDTH-1:0] fill_pattern;
        logic [ADDR_WIDTH-1:0] protected_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0] op;
        logic [ADDR_WIDTH-1:0] address;
        logic [DATA_WIDTH-1:0] write_data;
        logic done_res;
        logic failed;
        logic [ADDR_WIDTH-1:0] fail_address;
    } result_t;

endpackage

FILE: rtl/core/mit_cfg.sv
// mit_cfg: apb configuration registers of the memory test
// depends on mit_pkg
`timescale 1ns / 1ps

module mit_cfg
    import mit_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_WIDTH-1:0] paddr,
    input  logic [PDATA_WIDTH-1:0] pwdata,
    output logic [PDATA_WIDTH-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx = reg_idx_t'(paddr[3:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_address <= '0;
            cfg_reg.end_address <= '0;
            cfg_reg.fill_pattern <= PATTERN_RESET;
            cfg_reg.protected_limit <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_START:   cfg_reg.start_address <= pwdata;
                REG_END:     cfg_reg.end_address <= pwdata;
                REG_PATTERN: cfg_reg.fill_pattern <= pwdata;
                REG_LIMIT:   cfg_reg.protected_limit <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_START:   prdata = cfg_reg.start_address;
            REG_END:     prdata = cfg_reg.end_address;
            REG_PATTERN: prdata = cfg_reg.fill_pattern;
            REG_LIMIT:   prdata = cfg_reg.protected_limit;
            default:     prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/mit_core.sv
// mit_core: test sequencer state, step logic and result register
// depends on mit_pkg
`timescale 1ns / 1ps

module mit_core
    import mit_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_kind,
    input  logic [DATA_WIDTH-1:0] item_read_data,
    input  cfg_t                  cfg,
    output logic                  take,
    output logic                  out_valid,
    input  logic                  out_stall,
    output result_t               result
);

    phase_t                phase_reg, phase_next;
    logic [ADDR_WIDTH-1:0] cursor_reg, cursor_next;
    logic [ADDR_WIDTH-1:0] first_reg;
    logic                  out_valid_reg;
    result_t               result_reg, result_next;

    logic [ADDR_WIDTH-1:0] max_start, f, c, end_a;
    logic [DATA_WIDTH-1:0] pat, inv;
    logic                  fwd_ok, up_ok, dn_ok, back_ok;
    logic [1:0]            op_n;
    logic [ADDR_WIDTH-1:0] addr_n;
    logic [DATA_WIDTH-1:0] wd_n;

    assign take = item_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign result = result_reg;

    assign end_a = cfg.end_address;
    assign pat = cfg.fill_pattern;
    assign inv = ~cfg.fill_pattern;
    assign max_start = (cfg.start_address > cfg.protected_limit) ?
                       cfg.start_address : cfg.protected_limit;
    // a start item uses max_start directly; an advance item uses the latched first address and cursor
    assign f = item_kind ? first_reg : max_start;
    assign c = item_kind ? cursor_reg : max_start;

    assign fwd_ok = (c < end_a) && ((end_a - c) > WORD_STEP);
    assign up_ok = f < end_a;
    assign dn_ok = (end_a >= f) && ((end_a - f) >= WORD_STEP);
    assign back_ok = (c >= f) && ((c - f) >= WORD_STEP);

    always_comb
    begin
        phase_next = phase_reg;
        cursor_next = c;
        op_n = OP_NONE;
        addr_n = '0;
        wd_n = '0;
        if (!item_kind)
        begin
            if (up_ok)
            begin
                phase_next = PH_FILL;
                op_n = OP_WRITE;
                addr_n = c;
                wd_n = pat;
            end
            else
            begin
                // empty region: nothing to walk in either direction
                phase_next = PH_PASS;
            end
        end
        else
        begin
            unique case (phase_reg) inside
                PH_FILL, PH_UPWR:
                begin
                    if (fwd_ok)
                    begin
                        cursor_next = c + WORD_STEP;
                        phase_next = (phase_reg == PH_FILL) ? PH_FILL : PH_UPRD;
                        op_n = (phase_reg == PH_FILL) ? OP_WRITE : OP_READ;
                        addr_n = c + WORD_STEP;
                        wd_n = (phase_reg == PH_FILL) ? pat : '0;
                    end
                    else if (phase_reg == PH_FILL && up_ok)
                    begin
                        cursor_next = f;
                        phase_next = PH_UPRD;
                        op_n = OP_READ;
                        addr_n = f;
                    end
                    else if (dn_ok)
                    begin
                        cursor_next = end_a - WORD_STEP;
                        phase_next = PH_DNRD;
                        op_n = OP_READ;
                        addr_n = end_a - WORD_STEP;
                    end
                    else
                    begin
                        phase_next = PH_PASS;
                    end
                end
                PH_UPRD:
                begin
                    if (item_read_data != pat)
                    begin
                        phase_next = PH_FAIL;
                    end
                    else
                    begin
                        phase_next = PH_UPWR;
                        op_n = OP_WRITE;
                        addr_n = c;
                        wd_n = inv;
                    end
                end
                PH_DNRD:
                begin
                    if (item_read_data != inv)
                    begin
                        phase_next = PH_FAIL;
                    end
                    else
                    begin
                        phase_next = PH_DNWR;
                        op_n = OP_WRITE;
                        addr_n = c;
                        wd_n = pat;
                    end
                end
                PH_DNWR:
                begin
                    if (back_ok)
                    begin
                        cursor_next = c - WORD_STEP;
                        phase_next = PH_DNRD;
                        op_n = OP_READ;
                        addr_n = c - WORD_STEP;
                    end
                    else
                    begin
                        phase_next = PH_PASS;
                    end
                end
                default:
                begin
                    // idle, pass, fail: report only
                    phase_next = phase_reg;
                end
            endcase
        end

        result_next.op = op_n;
        result_next.address = addr_n;
        result_next.write_data = wd_n;
        result_next.done_res = (phase_next == PH_PASS) || (phase_next == PH_FAIL);
        result_next.failed = (phase_next == PH_FAIL);
        result_next.fail_address = (phase_next == PH_FAIL) ? cursor_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cursor_reg <= '0;
            first_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                cursor_reg <= cursor_next;
                if (!item_kind)
                begin
                    first_reg <= max_start;
                end
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

endmodule

FILE: rtl/core/moving_inversion_memory_test.sv
// moving_inversion_memory_test: top level with input register and apb config
// depends on mit_pkg, mit_cfg, mit_core
// an accepted item passes through the input register, then the result register
// throughput: one item per cycle while out_stall is low; the step logic updates phase and cursor
// in the same cycle it forms the result register's next value
// reset: asynchronous, clears the sequencer to idle and config to defaults
`timescale 1ns / 1ps

module moving_inversion_memory_test
    import mit_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_WIDTH-1:0] paddr,
    input  logic [PDATA_WIDTH-1:0] pwdata,
    output logic [PDATA_WIDTH-1:0] prdata,
    output logic                   pready,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   kind,
    input  logic [DATA_WIDTH-1:0]  read_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             op,
    output logic [ADDR_WIDTH-1:0]  address,
    output logic [DATA_WIDTH-1:0]  write_data,
    output logic                   done_res,
    output logic                   failed,
    output logic [ADDR_WIDTH-1:0]  fail_address
);

    cfg_t                  cfg;
    result_t               result;
    logic                  take;
    logic                  in_valid_reg;
    logic                  kind_reg;
    logic [DATA_WIDTH-1:0] read_data_reg;
    logic                  accept;

    // input register refills whenever its item moves on to the core
    assign in_stall = in_valid_reg && !take;
    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            read_data_reg <= read_data;
        end
    end

    mit_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mit_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (in_valid_reg),
        .item_kind      (kind_reg),
        .item_read_data (read_data_reg),
        .cfg            (cfg),
        .take           (take),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result         (result)
    );

    assign op = result.op;
    assign address = result.address;
    assign write_data = result.write_data;
    assign done_res = result.done_res;
    assign failed = result.failed;
    assign fail_address = result.fail_address;

endmodule

FILE: test/mit_access_checker.sv
// mit_access_checker: watches the config port and both item channels of the
// moving inversion memory test, predicts every access and compares it
// depends on mit_pkg for the result layout, register indexes, ops and phases
`timescale 1ns / 1ps

module mit_access_checker
    import mit_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic                   pready,
    input  logic [PADDR_WIDTH-1:0] paddr,
    input  logic [PDATA_WIDTH-1:0] pwdata,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   kind,
    input  logic [DATA_WIDTH-1:0]  read_data,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [1:0]             op,
    input  logic [ADDR_WIDTH-1:0]  address,
    input  logic [DATA_WIDTH-1:0]  write_data,
    input  logic                   done_res,
    input  logic                   failed,
    input  logic [ADDR_WIDTH-1:0]  fail_address,
    output int                     mismatches,
    output int                     outstanding,
    output int                     results_seen
);

    localparam int MAX_REPORTS = 20;

    typedef logic [ADDR_WIDTH-1:0] addr_t;
    typedef logic [DATA_WIDTH-1:0] data_t;

    addr_t    cfg_start;
    addr_t    cfg_end;
    data_t    cfg_pattern;
    addr_t    cfg_limit;
    phase_t   seq_phase;
    addr_t    cursor;
    addr_t    first_addr;
    result_t  expected_accesses[$];

    // result for the access just chosen, with done/fail flags from the new phase
    function automatic result_t access(op_t acc_op, addr_t acc_addr, data_t acc_data);
        result_t r;
        r.op = acc_op;
        r.address = acc_addr;
        r.write_data = acc_data;
        r.done_res = (seq_phase == PH_PASS) || (seq_phase == PH_FAIL);
        r.failed = (seq_phase == PH_FAIL);
        r.fail_address = r.failed ? cursor : '0;
        return r;
    endfunction

    function automatic result_t walk_down();
        if (cfg_end >= first_addr && cfg_end - first_addr >= WORD_STEP)
        begin
            cursor = cfg_end - WORD_STEP;
            seq_phase = PH_DNRD;
            return access(OP_READ, cursor, '0);
        end
        seq_phase = PH_PASS;
        return access(OP_NONE, '0, '0);
    endfunction

    function automatic result_t walk_up();
        if (first_addr < cfg_end)
        begin
            cursor = first_addr;
            seq_phase = PH_UPRD;
            return access(OP_READ, cursor, '0);
        end
        return walk_down();
    endfunction

    function automatic result_t next_access(logic is_advance, data_t rd);
        if (!is_advance)
        begin
            first_addr = (cfg_start > cfg_limit) ? cfg_start : cfg_limit;
            cursor = first_addr;
            if (first_addr < cfg_end)
            begin
                seq_phase = PH_FILL;
                return access(OP_WRITE, cursor, cfg_pattern);
            end
            return walk_up();
        end
        case (seq_phase)
            PH_FILL:
            begin
                if (cursor < cfg_end && cfg_end - cursor > WORD_STEP)
                begin
                    cursor += WORD_STEP;
                    return access(OP_WRITE, cursor, cfg_pattern);
                end
                return walk_up();
            end
            PH_UPRD:
            begin
                if (rd != cfg_pattern)
                begin
                    seq_phase = PH_FAIL;
                    return access(OP_NONE, '0, '0);
                end
                seq_phase = PH_UPWR;
                return access(OP_WRITE, cursor, ~cfg_pattern);
            end
            PH_UPWR:
            begin
                if (cursor < cfg_end && cfg_end - cursor > WORD_STEP)
                begin
                    cursor += WORD_STEP;
                    seq_phase = PH_UPRD;
                    return access(OP_READ, cursor, '0);
                end
                return walk_down();
            end
            PH_DNRD:
            begin
                if (rd != ~cfg_pattern)
                begin
                    seq_phase = PH_FAIL;
                    return access(OP_NONE, '0, '0);
                end
                seq_phase = PH_DNWR;
                return access(OP_WRITE, cursor, cfg_pattern);
            end
            PH_DNWR:
            begin
                // stop after the lowest word, never wrap below the first address
                if (cursor >= first_addr && cursor - first_addr >= WORD_STEP)
                begin
                    cursor -= WORD_STEP;
                    seq_phase = PH_DNRD;
                    return access(OP_READ, cursor, '0);
                end
                seq_phase = PH_PASS;
                return access(OP_NONE, '0, '0);
            end
            default:
                return access(OP_NONE, '0, '0);
        endcase
    endfunction

    function automatic void check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            cfg_start = '0;
            cfg_end = '0;
            cfg_pattern = PATTERN_RESET;
            cfg_limit = LIMIT_RESET;
            seq_phase = PH_IDLE;
            cursor = '0;
            first_addr = '0;
            expected_accesses.delete();
            mismatches = 0;
            results_seen = 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_START:   cfg_start = pwdata;
                    REG_END:     cfg_end = pwdata;
                    REG_PATTERN: cfg_pattern = pwdata;
                    REG_LIMIT:   cfg_limit = pwdata;
                    default:     ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_accesses.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t ns: result with no item pending, expected none, got op %0d addr %h",
                                 $time, op, address);
                end
                else
                begin
                    want = expected_accesses.pop_front();
                    check_field("op", 32'(want.op), 32'(op));
                    check_field("address", want.address, address);
                    check_field("write_data", want.write_data, write_data);
                    check_field("done_res", 32'(want.done_res), 32'(done_res));
                    check_field("failed", 32'(want.failed), 32'(failed));
                    check_field("fail_address", want.fail_address, fail_address);
                end
            end
            if (in_valid && !in_stall)
                expected_accesses.push_back(next_access(kind, read_data));
            outstanding <= expected_accesses.size();
        end
    end

endmodule

FILE: test/testbench.sv
// testbench: drives directed and random self-test runs into the memory test
// sequencer and reports the verdict; prediction lives in mit_access_checker
// depends on mit_pkg, mit_access_checker and moving_inversion_memory_test
`timescale 1ns / 1ps

module testbench;
    import mit_pkg::*;

    localparam int ITEMS_PER_MODE = 250;
    localparam int HOLD_CYCLES = 64;
    localparam int PLAN_CAP = 1000;

    // what the previous access was, which decides the read data of the next item
    typedef enum logic [1:0] {
        AFTER_WRITE,
        AFTER_UP_READ,
        AFTER_DOWN_READ
    } follow_t;

    typedef enum logic [1:0] {
        RUN_CLEAN,
        RUN_CUT,
        RUN_FAULT
    } run_style_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_WIDTH-1:0] paddr;
    logic [PDATA_WIDTH-1:0] pwdata;
    logic [PDATA_WIDTH-1:0] prdata;
    logic                   pready;
    logic                   in_valid;
    logic                   in_stall;
    logic                   kind;
    logic [DATA_WIDTH-1:0]  read_data;
    logic                   out_valid;
    logic                   out_stall;
    logic [1:0]             op;
    logic [ADDR_WIDTH-1:0]  address;
    logic [DATA_WIDTH-1:0]  write_data;
    logic                   done_res;
    logic                   failed;
    logic [ADDR_WIDTH-1:0]  fail_address;

    int mismatches;
    int outstanding;
    int results_seen;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int items_sent = 0;
    int settings_used = 0;
    int runs_started = 0;
    int faulty_runs = 0;

    logic [ADDR_WIDTH-1:0] cfg_start = '0;
    logic [ADDR_WIDTH-1:0] cfg_end = '0;
    logic [DATA_WIDTH-1:0] cfg_pattern = PATTERN_RESET;
    logic [ADDR_WIDTH-1:0] cfg_limit = LIMIT_RESET;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    moving_inversion_memory_test u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .read_data    (read_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .op           (op),
        .address      (address),
        .write_data   (write_data),
        .done_res     (done_res),
        .failed       (failed),
        .fail_address (fail_address)
    );

    mit_access_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .read_data    (read_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .op           (op),
        .address      (address),
        .write_data   (write_data),
        .done_res     (done_res),
        .failed       (failed),
        .fail_address (fail_address),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    // result side: random stalls, plus a long hold-off whenever one is requested
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_item(input logic is_advance, input logic [DATA_WIDTH-1:0] rd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            kind <= 1'($urandom);
            read_data <= $urandom;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= is_advance;
        read_data <= rd;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_WIDTH-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_WIDTH'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [ADDR_WIDTH-1:0] s, input logic [ADDR_WIDTH-1:0] e,
                                  input logic [DATA_WIDTH-1:0] p, input logic [ADDR_WIDTH-1:0] l);
        cfg_start = s;
        cfg_end = e;
        cfg_pattern = p;
        cfg_limit = l;
        write_reg(REG_START, s);
        write_reg(REG_END, e);
        write_reg(REG_PATTERN, p);
        write_reg(REG_LIMIT, l);
        settings_used++;
    endtask

    // mostly small regions, some empty, some at the bottom or top of the address space
    task automatic pick_settings();
        logic [ADDR_WIDTH-1:0] span;
        logic [ADDR_WIDTH-1:0] first;
        logic [ADDR_WIDTH-1:0] lower;
        logic [ADDR_WIDTH-1:0] e;
        logic [DATA_WIDTH-1:0] p;
        span = ($urandom_range(9) == 0) ? '0 : $urandom_range(48, 1);
        if ($urandom_range(19) == 0)
            span = $urandom_range(160, 49);
        first = $urandom;
        case ($urandom_range(4))
            0: first = '0;
            1: first = 32'hFFFF_FFFF - span;
            default: if ($urandom_range(3) != 0) first[1:0] = 2'b00;
        endcase
        if (first > 32'hFFFF_FFFF - span)
            first = 32'hFFFF_FFFF - span;
        e = first + span;
        if (span == 0 && $urandom_range(1) == 1)
            e = $urandom_range(first);
        lower = $urandom_range(first);
        case ($urandom_range(9))
            0: p = '0;
            1: p = '1;
            default: p = $urandom;
        endcase
        if ($urandom_range(1) == 1)
            apply_settings(first, e, p, lower);
        else
            apply_settings(lower, e, p, first);
    endtask

    // one start item, then advances that answer each read the way memory would, but for one flipped bit in a fault run
    task automatic run_test(input run_style_t run_style);
        logic [ADDR_WIDTH-1:0] first;
        logic [ADDR_WIDTH-1:0] span;
        logic [DATA_WIDTH-1:0] rd;
        int unsigned words_up;
        int unsigned words_down;
        follow_t plan[$];
        follow_t follow;
        int n_items;
        int fault_read;
        int reads;
        first = (cfg_start > cfg_limit) ? cfg_start : cfg_limit;
        words_up = 0;
        words_down = 0;
        if (first < cfg_end)
        begin
            span = cfg_end - first;
            words_up = span[31:2] + (span[1:0] != 2'b00);
            words_down = span[31:2];
        end
        for (int unsigned w = 0; w < words_up && plan.size() < PLAN_CAP; w++)
            plan.push_back(AFTER_WRITE);
        for (int unsigned w = 0; w < words_up && plan.size() < PLAN_CAP; w++)
        begin
            plan.push_back(AFTER_UP_READ);
            plan.push_back(AFTER_WRITE);
        end
        for (int unsigned w = 0; w < words_down && plan.size() < PLAN_CAP; w++)
        begin
            plan.push_back(AFTER_DOWN_READ);
            plan.push_back(AFTER_WRITE);
        end
        fault_read = -1;
        case (run_style)
            RUN_CUT:   n_items = (plan.size() > 0) ? $urandom_range(plan.size() - 1) : 0;
            RUN_FAULT:
            begin
                n_items = plan.size() + 1;
                if (words_up + words_down > 0)
                begin
                    fault_read = $urandom_range(words_up + words_down - 1);
                    faulty_runs++;
                end
            end
            default:   n_items = plan.size() + $urandom_range(2, 1);
        endcase
        runs_started++;
        send_item(1'b0, $urandom);
        reads = 0;
        for (int j = 0; j < n_items; j++)
        begin
            follow = (j < plan.size()) ? plan[j] : AFTER_WRITE;
            rd = $urandom;
            if (follow != AFTER_WRITE)
            begin
                rd = (follow == AFTER_UP_READ) ? cfg_pattern : ~cfg_pattern;
                if (reads == fault_read)
                    rd ^= DATA_WIDTH'(1) << $urandom_range(DATA_WIDTH - 1);
                reads++;
            end
            send_item(1'b1, rd);
        end
    endtask

    initial
    begin
        int budget;
        int pick;
        bit first_setting;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        kind <= 1'b0;
        read_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: advance while idle, empty region, advance after the pass
        send_item(1'b1, $urandom);
        send_item(1'b0, $urandom);
        send_item(1'b1, $urandom);
        wait_drain();
        // unaligned region ending at the top of the address space, zero pattern
        apply_settings(32'hFFFF_FFF8, 32'hFFFF_FFFF, '0, '0);
        run_test(RUN_CLEAN);
        wait_drain();
        // region shorter than one word above the protected limit, all-ones pattern
        apply_settings('0, 32'h0000_0043, '1, 32'h0000_0040);
        run_test(RUN_CUT);
        run_test(RUN_FAULT);

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 19;
                    recv_stall_pct = 78;
                end
                1:
                begin
                    send_idle_pct = 78;
                    recv_stall_pct = 19;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            budget = items_sent + ITEMS_PER_MODE;
            first_setting = 1'b1;
            while (items_sent < budget)
            begin
                wait_drain();
                pick_settings();
                // with nobody idling, hold results back so the block backs up
                if (mode == 2 && first_setting)
                    hold_requests++;
                first_setting = 1'b0;
                repeat ($urandom_range(2)) send_item(1'($urandom), $urandom);
                repeat ($urandom_range(4, 2))
                begin
                    pick = $urandom_range(99);
                    if (pick < 70)
                        run_test(RUN_CLEAN);
                    else if (pick < 85)
                        run_test(RUN_CUT);
                    else
                        run_test(RUN_FAULT);
                end
            end
        end

        wait_drain();
        repeat (8) @(posedge clk);
        $display("%0d items over %0d register settings, %0d test runs (%0d with a bad read)",
                 items_sent, settings_used, runs_started, faulty_runs);
        $display("%0d results compared, %0d long result hold-offs", results_seen, holds_served);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
